// ----- rtl/core/lvp_pkg.sv -----
// Shared types and constants for the line voltage from phase voltages unit.
// Holds the per-transaction control word, register codes and fixed-point constants.
// No dependencies.
`default_nettype none

package lvp_pkg;

  // Fixed-point constants: sqrt(3) in Q1.16 and sin(120 deg) as 887/1024.
  localparam int unsigned SQRT3_Q16    = 113512;
  localparam int unsigned SQRT3_SHIFT  = 16;
  localparam int unsigned SQRT3_BITS   = 17;
  localparam int unsigned PH_SIN_NUM   = 887;
  localparam int unsigned PH_SIN_SHIFT = 10;

  // Configuration bus shape.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register indexes, taken from paddr bit 2.
  localparam logic REG_CONN_MODE    = 1'b0;
  localparam logic REG_SINGLE_PHASE = 1'b1;

  // Control word that travels alongside each transaction through the lanes.
  typedef struct packed {
    logic valid;
    logic single;
    logic phasor;
  } lvp_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/lvp_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a sideband
// value and the control word carried alongside. Depends on lvp_pkg.
`default_nettype none

module lvp_sqrt #(
  parameter int unsigned NR  = 17,
  parameter int unsigned SBW = 17
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                advance,
  input  wire lvp_pkg::lvp_ctrl_t  ctrl_i,
  input  wire logic [2*NR-1:0]     rad_i,
  input  wire logic [SBW-1:0]      side_i,
  output      lvp_pkg::lvp_ctrl_t  ctrl_o,
  output      logic [NR-1:0]       root_o,
  output      logic [SBW-1:0]      side_o
);
  import lvp_pkg::*;

  // Per-stage pipeline registers.
  lvp_ctrl_t       ctrl_r [NR];
  logic [NR:0]     rem_r  [NR];
  logic [NR-1:0]   root_r [NR];
  logic [2*NR-1:0] rad_r  [NR];
  logic [SBW-1:0]  side_r [NR];

  genvar k;
  generate
    for (k = 0; k < NR; k++) begin : g_stage
      lvp_ctrl_t       ctrl_p;
      logic [NR:0]     rem_p;
      logic [NR-1:0]   root_p;
      logic [2*NR-1:0] rad_p;
      logic [SBW-1:0]  side_p;
      logic [NR+2:0]   cur;
      logic [NR+2:0]   trial;
      logic [NR+2:0]   diff;

      // The first stage starts from an empty remainder and root.
      if (k == 0) begin : g_first
        assign ctrl_p = ctrl_i;
        assign rem_p  = '0;
        assign root_p = '0;
        assign rad_p  = rad_i;
        assign side_p = side_i;
      end else begin : g_next
        assign ctrl_p = ctrl_r[k-1];
        assign rem_p  = rem_r[k-1];
        assign root_p = root_r[k-1];
        assign rad_p  = rad_r[k-1];
        assign side_p = side_r[k-1];
      end

      // Bring down the next two radicand bits and try the next root bit.
      assign cur   = {rem_p, rad_p[2*NR-1 -: 2]};
      assign trial = {1'b0, root_p, 2'b01};
      assign diff  = cur - trial;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ctrl_r[k] <= '0;
        end else if (advance) begin
          ctrl_r[k] <= ctrl_p;
        end
      end

      always_ff @(posedge clk) begin
        if (advance) begin
          if (cur >= trial) begin
            rem_r[k]  <= diff[NR:0];
            root_r[k] <= {root_p[NR-2:0], 1'b1};
          end else begin
            rem_r[k]  <= cur[NR:0];
            root_r[k] <= {root_p[NR-2:0], 1'b0};
          end
          rad_r[k]  <= rad_p << 2;
          side_r[k] <= side_p;
        end
      end
    end
  endgenerate

  assign ctrl_o = ctrl_r[NR-1];
  assign root_o = root_r[NR-1];
  assign side_o = side_r[NR-1];

  // A finished root leaves a remainder no larger than twice the root.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_o.valid |-> (rem_r[NR-1] <= {root_o, 1'b0}))
    else $error("square root remainder out of bound");

endmodule

`default_nettype wire

// ----- rtl/core/lvp_lane.sv -----
// One lane: forms the averaged and phasor operands for a phase pair, squares
// and sums them, then runs the pipelined square root. Depends on lvp_pkg, lvp_sqrt.
`default_nettype none

module lvp_lane #(
  parameter int unsigned VOLT_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  advance,
  input  wire lvp_pkg::lvp_ctrl_t    ctrl_i,
  input  wire logic [VOLT_WIDTH-1:0] a_i,
  input  wire logic [VOLT_WIDTH-1:0] b_i,
  output      lvp_pkg::lvp_ctrl_t    ctrl_o,
  output      logic [VOLT_WIDTH:0]   root_o,
  output      logic [VOLT_WIDTH:0]   lin_o
);
  import lvp_pkg::*;

  localparam int unsigned VW  = VOLT_WIDTH;
  localparam int unsigned NR  = VW + 1;
  localparam int unsigned YPW = VW + PH_SIN_SHIFT;
  localparam int unsigned LPW = VW + SQRT3_BITS;

  // Stage one: phasor components and the operand for the sqrt(3) product.
  logic [VW:0]    x_nxt;
  logic [YPW-1:0] yprod;
  logic [VW:0]    pair_sum;
  logic [VW-1:0]  v_nxt;

  lvp_ctrl_t      ctrl1_r;
  logic [VW:0]    x_r;
  logic [VW-1:0]  y_r;
  logic [VW-1:0]  v_r;

  assign x_nxt    = NR'(a_i) + NR'(b_i[VW-1:1]);
  assign yprod    = YPW'(b_i) * YPW'(PH_SIN_NUM);
  assign pair_sum = NR'(a_i) + NR'(b_i);
  assign v_nxt    = ctrl_i.single ? a_i : pair_sum[VW:1];

  // Stage two: squares and the truncated sqrt(3) product.
  logic [2*NR-1:0] xx_nxt;
  logic [2*VW-1:0] yy_nxt;
  logic [LPW-1:0]  lprod;

  lvp_ctrl_t       ctrl2_r;
  logic [2*NR-1:0] xx_r;
  logic [2*VW-1:0] yy_r;
  logic [VW:0]     lin1_r;

  assign xx_nxt = (2*NR)'(x_r) * (2*NR)'(x_r);
  assign yy_nxt = (2*VW)'(y_r) * (2*VW)'(y_r);
  assign lprod  = LPW'(v_r) * LPW'(SQRT3_Q16);

  // Stage three: sum of squares feeding the root.
  lvp_ctrl_t       ctrl3_r;
  logic [2*NR-1:0] sum_r;
  logic [VW:0]     lin2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl1_r <= '0;
      ctrl2_r <= '0;
      ctrl3_r <= '0;
    end else if (advance) begin
      ctrl1_r <= ctrl_i;
      ctrl2_r <= ctrl1_r;
      ctrl3_r <= ctrl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_r    <= x_nxt;
      y_r    <= yprod[YPW-1:PH_SIN_SHIFT];
      v_r    <= v_nxt;
      xx_r   <= xx_nxt;
      yy_r   <= yy_nxt;
      lin1_r <= lprod[LPW-1:SQRT3_SHIFT];
      sum_r  <= xx_r + (2*NR)'(yy_r);
      lin2_r <= lin1_r;
    end
  end

  // Square root, with the sqrt(3) result riding alongside.
  lvp_sqrt #(
    .NR  (NR),
    .SBW (NR)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .ctrl_i  (ctrl3_r),
    .rad_i   (sum_r),
    .side_i  (lin2_r),
    .ctrl_o  (ctrl_o),
    .root_o  (root_o),
    .side_o  (lin_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/lvp_merge.sv -----
// Merging stage: picks each line voltage from the lane results by mode,
// saturates it and holds it in the output register. Depends on lvp_pkg.
`default_nettype none

module lvp_merge #(
  parameter int unsigned VOLT_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lvp_pkg::lvp_ctrl_t    ctrl_i,
  input  wire logic [VOLT_WIDTH:0]   root_rs_i,
  input  wire logic [VOLT_WIDTH:0]   root_st_i,
  input  wire logic [VOLT_WIDTH:0]   root_rt_i,
  input  wire logic [VOLT_WIDTH:0]   lin_rs_i,
  input  wire logic [VOLT_WIDTH:0]   lin_st_i,
  input  wire logic [VOLT_WIDTH:0]   lin_rt_i,
  input  wire logic                  out_ready_i,
  output      logic                  advance_o,
  output      logic                  out_valid_o,
  output      logic [VOLT_WIDTH-1:0] line_rs_o,
  output      logic [VOLT_WIDTH-1:0] line_st_o,
  output      logic [VOLT_WIDTH-1:0] line_rt_o
);
  import lvp_pkg::*;

  localparam int unsigned VW = VOLT_WIDTH;

  // Clamp a result that carries one bit of headroom.
  function automatic logic [VW-1:0] sat_volt(input logic [VW:0] v);
    sat_volt = v[VW] ? {VW{1'b1}} : v[VW-1:0];
  endfunction

  logic          out_valid_r;
  logic [VW-1:0] rs_r, st_r, rt_r;
  logic [VW-1:0] rs_nxt, st_nxt, rt_nxt;

  // Mode selection; single phase wins over the connection mode.
  always_comb begin
    if (ctrl_i.single) begin
      rs_nxt = sat_volt(lin_rs_i);
      st_nxt = '0;
      rt_nxt = '0;
    end else if (ctrl_i.phasor) begin
      rs_nxt = sat_volt(root_rs_i);
      st_nxt = sat_volt(root_st_i);
      rt_nxt = sat_volt(root_rt_i);
    end else begin
      rs_nxt = sat_volt(lin_rs_i);
      st_nxt = sat_volt(lin_st_i);
      rt_nxt = sat_volt(lin_rt_i);
    end
  end

  // The whole pipeline moves unless a held result is being refused.
  assign advance_o = !out_valid_r || out_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance_o) begin
      out_valid_r <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_o && ctrl_i.valid) begin
      rs_r <= rs_nxt;
      st_r <= st_nxt;
      rt_r <= rt_nxt;
    end
  end

  assign out_valid_o = out_valid_r;
  assign line_rs_o   = rs_r;
  assign line_st_o   = st_r;
  assign line_rt_o   = rt_r;

  // The pipeline only freezes behind a result that is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !advance_o |-> out_valid_r)
    else $error("pipeline stalled without a pending result");

  // A refused result must still be there in the next cycle.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready_i) |=> (out_valid_r && $stable(rs_r)))
    else $error("pending result lost while stalled");

endmodule

`default_nettype wire

// ----- rtl/core/line_voltage_from_phase_voltages_unit.sv -----
// Top level of the line voltage from phase voltages unit: configuration
// registers, three lanes and the merging stage. Depends on lvp_pkg, lvp_lane, lvp_merge.
//
//   Channel  Direction  Handshake            Payload
//   config   in         psel/penable/pready  paddr, pwdata, prdata
//   input    in         in_valid/in_ready    in_phase_r, in_phase_s, in_phase_t
//   result   out        out_valid/out_ready  out_line_rs, out_line_st, out_line_rt
//
// One transaction enters per cycle while no result is refused; each passes
// three operand stages, VOLT_WIDTH + 1 root stages in each lane and the output
// register. The root stages make up most of that path.
// rst_n is synchronous and clears all valid flags and both registers to zero.
// A refused result freezes every stage; in_ready drops only then.
`default_nettype none

module line_voltage_from_phase_voltages_unit #(
  parameter int unsigned VOLT_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lvp_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [lvp_pkg::PDATA_W-1:0]    pwdata,
  output      logic [lvp_pkg::PDATA_W-1:0]    prdata,
  output      logic                           pready,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [VOLT_WIDTH-1:0]          in_phase_r,
  input  wire logic [VOLT_WIDTH-1:0]          in_phase_s,
  input  wire logic [VOLT_WIDTH-1:0]          in_phase_t,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [VOLT_WIDTH-1:0]          out_line_rs,
  output      logic [VOLT_WIDTH-1:0]          out_line_st,
  output      logic [VOLT_WIDTH-1:0]          out_line_rt
);
  import lvp_pkg::*;

  localparam int unsigned VW = VOLT_WIDTH;

  // Configuration registers.
  logic conn_mode_r;
  logic single_phase_r;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_mode_r    <= 1'b0;
      single_phase_r <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_CONN_MODE:    conn_mode_r    <= pwdata[0];
        REG_SINGLE_PHASE: single_phase_r <= pwdata[0];
        default:          ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_CONN_MODE:    prdata = PDATA_W'(conn_mode_r);
      REG_SINGLE_PHASE: prdata = PDATA_W'(single_phase_r);
      default:          prdata = '0;
    endcase
  end

  // Control word entering every lane with the transaction.
  lvp_ctrl_t ctrl_in;
  logic      advance;

  assign ctrl_in.valid  = in_valid;
  assign ctrl_in.single = single_phase_r;
  assign ctrl_in.phasor = conn_mode_r;
  assign in_ready       = advance;

  // Three lanes, one per phase pair: (r,s), (s,t) and (t,r).
  lvp_ctrl_t   ctrl_l [3];
  logic [VW:0] root_l [3];
  logic [VW:0] lin_l  [3];

  lvp_lane #(.VOLT_WIDTH(VW)) u_lane_rs (
    .clk(clk), .rst_n(rst_n), .advance(advance), .ctrl_i(ctrl_in),
    .a_i(in_phase_r), .b_i(in_phase_s),
    .ctrl_o(ctrl_l[0]), .root_o(root_l[0]), .lin_o(lin_l[0])
  );

  lvp_lane #(.VOLT_WIDTH(VW)) u_lane_st (
    .clk(clk), .rst_n(rst_n), .advance(advance), .ctrl_i(ctrl_in),
    .a_i(in_phase_s), .b_i(in_phase_t),
    .ctrl_o(ctrl_l[1]), .root_o(root_l[1]), .lin_o(lin_l[1])
  );

  lvp_lane #(.VOLT_WIDTH(VW)) u_lane_rt (
    .clk(clk), .rst_n(rst_n), .advance(advance), .ctrl_i(ctrl_in),
    .a_i(in_phase_t), .b_i(in_phase_r),
    .ctrl_o(ctrl_l[2]), .root_o(root_l[2]), .lin_o(lin_l[2])
  );

  // Merge the lane results into the output register.
  lvp_merge #(.VOLT_WIDTH(VW)) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl_i      (ctrl_l[0]),
    .root_rs_i   (root_l[0]),
    .root_st_i   (root_l[1]),
    .root_rt_i   (root_l[2]),
    .lin_rs_i    (lin_l[0]),
    .lin_st_i    (lin_l[1]),
    .lin_rt_i    (lin_l[2]),
    .out_ready_i (out_ready),
    .advance_o   (advance),
    .out_valid_o (out_valid),
    .line_rs_o   (out_line_rs),
    .line_st_o   (out_line_st),
    .line_rt_o   (out_line_rt)
  );

  // The lanes run in lockstep, so their control words always agree.
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_l[0] == ctrl_l[1]) && (ctrl_l[0] == ctrl_l[2]))
    else $error("lane control words out of step");

endmodule

`default_nettype wire

// ----- bench/lvp_checker.sv -----
// Scoreboard for the line voltage from phase voltages unit: watches the register
// port and both channels, predicts each result and compares it field by field.
// Depends on lvp_pkg for the register codes and the fixed-point constants.
`default_nettype none

module lvp_checker #(
  parameter int unsigned VOLT_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lvp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [lvp_pkg::PDATA_W-1:0] pwdata,
  input  wire logic                        pready,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [VOLT_WIDTH-1:0]       in_phase_r,
  input  wire logic [VOLT_WIDTH-1:0]       in_phase_s,
  input  wire logic [VOLT_WIDTH-1:0]       in_phase_t,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [VOLT_WIDTH-1:0]       out_line_rs,
  input  wire logic [VOLT_WIDTH-1:0]       out_line_st,
  input  wire logic [VOLT_WIDTH-1:0]       out_line_rt,
  output int                               fail_count,
  output int                               pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VOLT_WIDTH-1:0] rs;
    logic [VOLT_WIDTH-1:0] st;
    logic [VOLT_WIDTH-1:0] rt;
  } line_set_t;

  localparam longint unsigned VOLT_MAX = (64'd1 << VOLT_WIDTH) - 64'd1;

  // Shadow copy of the two configuration bits.
  logic      mode_phasor;
  logic      mode_single;
  line_set_t expected_lines[$];
  int        errs;

  function automatic longint unsigned clamp_volt(longint unsigned v);
    return (v > VOLT_MAX) ? VOLT_MAX : v;
  endfunction

  // Floor of the square root, found one result bit at a time from the top.
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic longint unsigned scale_sqrt3(longint unsigned v);
    return clamp_volt((v * lvp_pkg::SQRT3_Q16) >> lvp_pkg::SQRT3_SHIFT);
  endfunction

  // Line voltage of a phase pair from the 120 degree phasor sum.
  function automatic longint unsigned phasor_line(longint unsigned a, longint unsigned b);
    longint unsigned x;
    longint unsigned y;
    x = a + (b >> 1);
    y = (b * lvp_pkg::PH_SIN_NUM) >> lvp_pkg::PH_SIN_SHIFT;
    return clamp_volt(floor_root(x * x + y * y));
  endfunction

  function automatic line_set_t predict_lines(longint unsigned r, longint unsigned s,
                                              longint unsigned t);
    line_set_t ls;
    if (mode_single) begin
      ls.rs = VOLT_WIDTH'(scale_sqrt3(r));
      ls.st = '0;
      ls.rt = '0;
    end else if (!mode_phasor) begin
      ls.rs = VOLT_WIDTH'(scale_sqrt3((r + s) >> 1));
      ls.st = VOLT_WIDTH'(scale_sqrt3((s + t) >> 1));
      ls.rt = VOLT_WIDTH'(scale_sqrt3((r + t) >> 1));
    end else begin
      ls.rs = VOLT_WIDTH'(phasor_line(r, s));
      ls.st = VOLT_WIDTH'(phasor_line(s, t));
      ls.rt = VOLT_WIDTH'(phasor_line(t, r));
    end
    return ls;
  endfunction

  task automatic compare_field(string field, logic [VOLT_WIDTH-1:0] exp_v,
                               logic [VOLT_WIDTH-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
      errs++;
    end
  endtask

  // All bookkeeping happens at the rising edge, on values settled since the falling edge.
  always @(posedge clk) begin
    line_set_t want;
    if (!rst_n) begin
      mode_phasor = 1'b0;
      mode_single = 1'b0;
      expected_lines.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == lvp_pkg::REG_CONN_MODE) mode_phasor = pwdata[0];
        else mode_single = pwdata[0];
      end
      // Retire a result before booking the transaction accepted on the same edge.
      if (out_valid && out_ready) begin
        if (expected_lines.size() == 0) begin
          $error("result transaction with no expectation waiting: rs %0d st %0d rt %0d",
                 out_line_rs, out_line_st, out_line_rt);
          errs++;
        end else begin
          want = expected_lines.pop_front();
          compare_field("line_rs", want.rs, out_line_rs);
          compare_field("line_st", want.st, out_line_st);
          compare_field("line_rt", want.rt, out_line_rt);
        end
      end
      if (in_valid && in_ready)
        expected_lines.push_back(predict_lines(in_phase_r, in_phase_s, in_phase_t));
    end
    fail_count <= errs;
    pending    <= expected_lines.size();
  end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Top of the bench for the line voltage from phase voltages unit: clock, reset,
// register writes, phase voltage stimulus, result back-pressure and the verdict.
// Depends on lvp_pkg, the unit itself and lvp_checker.
`default_nettype none

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW       = 16;
  localparam int unsigned VMAX     = (1 << VW) - 1;
  localparam int          DRAIN    = 40;
  localparam int          HOLD_LEN = 300;
  localparam int          PHASE_N  = 225;

  logic                        clk      = 1'b0;
  logic                        rst_n    = 1'b0;
  logic                        psel     = 1'b0;
  logic                        penable  = 1'b0;
  logic                        pwrite   = 1'b0;
  logic [lvp_pkg::PADDR_W-1:0] paddr    = '0;
  logic [lvp_pkg::PDATA_W-1:0] pwdata   = '0;
  logic [lvp_pkg::PDATA_W-1:0] prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [VW-1:0]               in_phase_r = '0;
  logic [VW-1:0]               in_phase_s = '0;
  logic [VW-1:0]               in_phase_t = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [VW-1:0]               out_line_rs;
  logic [VW-1:0]               out_line_st;
  logic [VW-1:0]               out_line_rt;

  int fail_count;
  int pending;

  // Stimulus knobs: quiet turns idling off on both sides; a bump of the hold-off
  // request makes the receiver refuse results for a long stretch.
  bit quiet         = 1'b0;
  int holdoff_asked = 0;
  int holdoff_seen  = 0;

  line_voltage_from_phase_voltages_unit #(.VOLT_WIDTH(VW)) i_dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .in_phase_r, .in_phase_s, .in_phase_t,
    .out_valid, .out_ready, .out_line_rs, .out_line_st, .out_line_rt
  );

  lvp_checker #(.VOLT_WIDTH(VW)) i_checker (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_ready, .in_phase_r, .in_phase_s, .in_phase_t,
    .out_valid, .out_ready, .out_line_rs, .out_line_st, .out_line_rt,
    .fail_count, .pending
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random refusals, none when quiet, and a counted hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_asked != holdoff_seen) begin
        holdoff_seen = holdoff_asked;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 23);
      end
    end
  end

  // Safety net against a hung handshake.
  initial begin
    #4_000_000;
    $display("line_voltage_from_phase_voltages_unit verification failed");
    $finish;
  end

  // Register write over the APB-style port; upper data bits carry random noise.
  task automatic reg_write(logic idx, bit val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom() & ~32'h1) | val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering and let every outstanding result come out of the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic apply_settings(bit phasor, bit single);
    settle();
    reg_write(lvp_pkg::REG_CONN_MODE, phasor);
    reg_write(lvp_pkg::REG_SINGLE_PHASE, single);
  endtask

  // Offer one set of phase voltages and hold it until the unit takes it.
  task automatic send_phases(logic [VW-1:0] r, logic [VW-1:0] s, logic [VW-1:0] t);
    while (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_phase_r <= r;
    in_phase_s <= s;
    in_phase_t <= t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Voltage mix: mostly uniform, with zero, full scale and both ends of the range.
  function automatic logic [VW-1:0] pick_volt();
    case ($urandom_range(9))
      0:       return '0;
      1:       return VW'(VMAX);
      2:       return VW'($urandom_range(255));
      3:       return VW'($urandom_range(VMAX, VMAX - 600));
      default: return VW'($urandom_range(VMAX));
    endcase
  endfunction

  initial begin
    bit phasor_list[8] = '{0, 1, 0, 1, 1, 0, 1, 0};
    bit single_list[8] = '{0, 0, 1, 1, 0, 0, 1, 1};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed vectors under every setting: zeros, full scale, lone phases,
    // odd sums that need truncation and a typical balanced supply.
    for (int c = 0; c < 4; c++) begin
      apply_settings(c[0], c[1]);
      send_phases('0, '0, '0);
      send_phases(VW'(VMAX), VW'(VMAX), VW'(VMAX));
      send_phases(VW'(VMAX), '0, '0);
      send_phases('0, VW'(VMAX), 16'd1);
      send_phases(16'd1, 16'd2, 16'd3);
      send_phases(16'd23001, 16'd22998, 16'd23005);
    end

    // Random phases, one setting each; the second is back-pressured hard and
    // the third runs with no idling on either side.
    for (int p = 0; p < 8; p++) begin
      apply_settings(phasor_list[p], single_list[p]);
      quiet = (p == 2);
      for (int k = 0; k < PHASE_N; k++) begin
        if (p == 1 && k == 50) holdoff_asked++;
        send_phases(pick_volt(), pick_volt(), pick_volt());
      end
      quiet = 1'b0;
    end

    settle();
    if (fail_count == 0) begin
      $display("line_voltage_from_phase_voltages_unit verification clean");
    end else begin
      $display("line_voltage_from_phase_voltages_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
